// ----- hw/rtl/interval_set_merge_insert_assert.svh -----
// assertion macros for the interval set block
`ifndef INTERVAL_SET_MERGE_INSERT_ASSERT_SVH
`define INTERVAL_SET_MERGE_INSERT_ASSERT_SVH
`ifndef SYNTH
`define ISMS_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("isms: check failed");
`define ISMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("isms: check failed");
`else
`define ISMS_ASSERT(lbl, ante, cons)
`define ISMS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/isms_pkg.sv -----
package isms_pkg;

  // default sizes
  localparam int DEF_NUM_SETS      = 4;
  localparam int DEF_MAX_INTERVALS = 16;
  localparam int DEF_COORD_BITS    = 32;

  // fixed field widths
  localparam int OPCODE_W = 2;
  localparam int SET_W    = 2;
  localparam int ENTRY_W  = 4;
  localparam int FIELD_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_BAD      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_EVAL,
    S_FINAL,
    S_COMMIT,
    S_FETCH,
    S_RESP
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic rd_entry;
    logic eval;
    logic finish;
    logic commit;
    logic rd_pos;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;
    logic op_insert;
    logic op_clear;
    logic op_read;
    logic k_done;
    logic adv;
  } sts_t;

endpackage

// ----- hw/rtl/isms_in_if.sv -----
interface isms_in_if
  import isms_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [SET_W-1:0]           set_index;
  logic [ENTRY_W-1:0]         entry_index;
  logic signed [FIELD_W-1:0]  range_low;
  logic signed [FIELD_W-1:0]  range_high;

  modport source (output valid, opcode, set_index, entry_index, range_low, range_high,
                  input ready);
  modport sink (input valid, opcode, set_index, entry_index, range_low, range_high,
                output ready);
endinterface

// ----- hw/rtl/isms_out_if.sv -----
interface isms_out_if
  import isms_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic [COUNT_W-1:0]         interval_count;
  logic signed [FIELD_W-1:0]  entry_low;
  logic signed [FIELD_W-1:0]  entry_high;

  modport source (output valid, status, interval_count, entry_low, entry_high,
                  input ready);
  modport sink (input valid, status, interval_count, entry_low, entry_high,
                output ready);
endinterface

// ----- hw/rtl/isms_ram.sv -----
module isms_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hw/rtl/isms_ctrl.sv -----
module isms_ctrl
  import isms_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // state and result valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.bad) begin
          state_d = S_RESP;
        end else if (sts_i.op_insert) begin
          state_d = S_READ;
        end else if (sts_i.op_clear) begin
          cmd_o.clear = 1'b1;
          state_d     = S_RESP;
        end else if (sts_i.op_read) begin
          state_d = S_FETCH;
        end else begin
          state_d = S_RESP;
        end
      end
      S_READ: begin
        if (sts_i.k_done) begin
          state_d = S_FINAL;
        end else begin
          cmd_o.rd_entry = 1'b1;
          state_d        = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.adv) begin
          state_d = S_READ;
        end
      end
      S_FINAL: begin
        cmd_o.finish = 1'b1;
        state_d      = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_RESP;
      end
      S_FETCH: begin
        cmd_o.rd_pos = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result slot: set on emit, cleared when taken
  assign out_valid_d = cmd_o.emit | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/isms_dp.sv -----
`include "interval_set_merge_insert_assert.svh"
module isms_dp
  import isms_pkg::*;
#(
  parameter int NUM_SETS      = DEF_NUM_SETS,
  parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
  parameter int COORD_BITS    = DEF_COORD_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o,
  input  logic [OPCODE_W-1:0]       opcode_i,
  input  logic [SET_W-1:0]          set_index_i,
  input  logic [ENTRY_W-1:0]        entry_index_i,
  input  logic signed [FIELD_W-1:0] range_low_i,
  input  logic signed [FIELD_W-1:0] range_high_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic [COUNT_W-1:0]        interval_count_o,
  output logic signed [FIELD_W-1:0] entry_low_o,
  output logic signed [FIELD_W-1:0] entry_high_o
);

  localparam int CW  = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int XW  = CW + 1;
  localparam int SW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int NW  = $clog2(MAX_INTERVALS);
  localparam int CNW = $clog2(MAX_INTERVALS + 1);
  localparam int AW  = SW + 1 + NW;
  localparam logic signed [XW-1:0] ONE_X = XW'(1);
  localparam logic [CNW-1:0] MAX_CNT = CNW'(MAX_INTERVALS);

  // latched operation
  logic [OPCODE_W-1:0]   op_q;
  logic                  set_ok_q;
  logic [SW-1:0]         set_q;
  logic [ENTRY_W-1:0]    idx_q;
  logic                  bad_q;
  // merge state
  logic signed [CW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [CNW-1:0]        k_q, k_d, n_q, n_d;
  logic                  placed_q, placed_d, ovf_q, ovf_d;
  // per set state
  logic [CNW-1:0]        cnt_q [NUM_SETS];
  logic [NUM_SETS-1:0]   bank_q;
  // result register
  logic [STATUS_W-1:0]   out_status_q;
  logic [COUNT_W-1:0]    out_count_q;
  logic signed [FIELD_W-1:0] out_low_q, out_high_q;

  logic [CNW-1:0]        cnt_cur;
  logic                  bank_cur;
  logic [SW-1:0]         in_set;
  logic                  in_ok;
  logic [CNW-1:0]        in_cnt;
  logic signed [CW-1:0]  in_lo, in_hi;
  logic                  in_bad;
  logic                  ram_we, ram_re, want_write;
  logic                  adv;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [2*CW-1:0]       ram_wdata, ram_rdata;
  logic signed [CW-1:0]  ent_lo, ent_hi;
  logic signed [XW-1:0]  ent_lo_x, ent_hi_x, cur_lo_x, cur_hi_x;
  logic                  below, above;
  logic [STATUS_W-1:0]   res_status;

  // addressed set
  assign cnt_cur  = set_ok_q ? cnt_q[set_q] : '0;
  assign bank_cur = set_ok_q & bank_q[set_q];

  // check the incoming item
  assign in_set = SW'(set_index_i);
  assign in_ok  = 32'(set_index_i) < 32'(NUM_SETS);
  assign in_cnt = in_ok ? cnt_q[in_set] : '0;
  assign in_lo  = range_low_i[CW-1:0];
  assign in_hi  = range_high_i[CW-1:0];
  always_comb begin
    in_bad = !in_ok;
    case (opcode_i)
      OP_INSERT: in_bad = in_bad | (in_lo > in_hi);
      OP_CLEAR:  in_bad = in_bad;
      OP_READ:   in_bad = in_bad | (32'(entry_index_i) >= 32'(in_cnt));
      default:   in_bad = 1'b1;
    endcase
  end

  // stored entry against the growing interval, one bit wider so nothing wraps
  assign ent_lo   = ram_rdata[2*CW-1:CW];
  assign ent_hi   = ram_rdata[CW-1:0];
  assign ent_lo_x = XW'(ent_lo);
  assign ent_hi_x = XW'(ent_hi);
  assign cur_lo_x = XW'(lo_q);
  assign cur_hi_x = XW'(hi_q);
  assign below    = (ent_hi_x + ONE_X) < cur_lo_x;
  assign above    = ent_lo_x > (cur_hi_x + ONE_X);

  // merge step
  always_comb begin
    lo_d       = lo_q;
    hi_d       = hi_q;
    k_d        = k_q;
    placed_d   = placed_q;
    want_write = 1'b0;
    ram_wdata  = {ent_lo, ent_hi};
    adv        = 1'b1;
    if (cmd_i.eval) begin
      if (below) begin
        want_write = 1'b1;
        k_d        = k_q + CNW'(1);
      end else if (above) begin
        want_write = 1'b1;
        if (!placed_q) begin
          ram_wdata = {lo_q, hi_q};
          placed_d  = 1'b1;
          adv       = 1'b0;
        end else begin
          k_d = k_q + CNW'(1);
        end
      end else begin
        if (ent_lo < lo_q) lo_d = ent_lo;
        if (ent_hi > hi_q) hi_d = ent_hi;
        k_d = k_q + CNW'(1);
      end
    end else if (cmd_i.finish && !placed_q) begin
      want_write = 1'b1;
      ram_wdata  = {lo_q, hi_q};
    end
  end

  // write into the spare bank, never past capacity
  assign ram_we    = want_write & (n_q < MAX_CNT);
  assign ovf_d     = ovf_q | (want_write & (n_q == MAX_CNT));
  assign n_d       = ram_we ? n_q + CNW'(1) : n_q;
  assign ram_waddr = {set_q, ~bank_cur, n_q[NW-1:0]};
  assign ram_re    = cmd_i.rd_entry | cmd_i.rd_pos;
  assign ram_raddr = cmd_i.rd_pos ? {set_q, bank_cur, NW'(idx_q)}
                                  : {set_q, bank_cur, k_q[NW-1:0]};

  isms_ram #(
    .WIDTH (2 * CW),
    .DEPTH (2 ** AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // operation registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= '0;
      set_ok_q <= 1'b0;
      set_q    <= '0;
      idx_q    <= '0;
      bad_q    <= 1'b0;
      lo_q     <= '0;
      hi_q     <= '0;
      k_q      <= '0;
      n_q      <= '0;
      placed_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else if (cmd_i.load) begin
      op_q     <= opcode_i;
      set_ok_q <= in_ok;
      set_q    <= in_set;
      idx_q    <= entry_index_i;
      bad_q    <= in_bad;
      lo_q     <= in_lo;
      hi_q     <= in_hi;
      k_q      <= '0;
      n_q      <= '0;
      placed_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      k_q      <= k_d;
      n_q      <= n_d;
      placed_q <= placed_d;
      ovf_q    <= ovf_d;
    end
  end

  // set counts and bank selects
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SETS; i++) begin
        cnt_q[i] <= '0;
      end
      bank_q <= '0;
    end else if (cmd_i.clear) begin
      cnt_q[set_q] <= '0;
    end else if (cmd_i.commit && !ovf_q) begin
      cnt_q[set_q]  <= n_q;
      bank_q[set_q] <= ~bank_cur;
    end
  end

  // result
  always_comb begin
    if (bad_q) begin
      res_status = ST_BAD;
    end else if (op_q == OP_INSERT && ovf_q) begin
      res_status = ST_OVERFLOW;
    end else begin
      res_status = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= res_status;
      out_count_q  <= COUNT_W'(cnt_cur);
      if (!bad_q && op_q == OP_READ) begin
        out_low_q  <= FIELD_W'(ent_lo);
        out_high_q <= FIELD_W'(ent_hi);
      end else begin
        out_low_q  <= '0;
        out_high_q <= '0;
      end
    end
  end

  assign status_o         = out_status_q;
  assign interval_count_o = out_count_q;
  assign entry_low_o      = out_low_q;
  assign entry_high_o     = out_high_q;

  // status to controller
  assign sts_o.bad       = bad_q;
  assign sts_o.op_insert = op_q == OP_INSERT;
  assign sts_o.op_clear  = op_q == OP_CLEAR;
  assign sts_o.op_read   = op_q == OP_READ;
  assign sts_o.k_done    = k_q == cnt_cur;
  assign sts_o.adv       = adv;

  `ISMS_ASSERT(a_wr_in_range, ram_we, n_q < MAX_CNT)
  `ISMS_ASSERT(a_cnt_bound, 1'b1, cnt_cur <= MAX_CNT)
  `ISMS_ASSERT_NEXT(a_ovf_keeps_set, cmd_i.commit && ovf_q, $stable(cnt_cur))
  `ISMS_ASSERT_NEXT(a_bad_reported, cmd_i.emit && bad_q, out_status_q == ST_BAD)

endmodule

// ----- hw/rtl/interval_set_merge_insert.sv -----
// channel  dir  fields                                                    handshake
// in_i     in   opcode set_index entry_index range_low range_high         valid/ready
// out_o    out  status interval_count entry_low entry_high                valid/ready
//
// one item at a time; an insert does one read and one evaluate per stored entry
// through the single ram read port, and one extra evaluate step when the
// new interval goes in ahead of a stored entry
// reset clears all set counts; the interval store itself needs no clearing
// a new item is taken while the previous result still waits in the output register;
// a full output register holds the block in its result state

module interval_set_merge_insert
  import isms_pkg::*;
#(
  parameter int NUM_SETS      = DEF_NUM_SETS,
  parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
  parameter int COORD_BITS    = DEF_COORD_BITS
) (
  input logic        clk_i,
  input logic        rst_ni,
  isms_in_if.sink    in_i,
  isms_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  isms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // store, merge logic and result register
  isms_dp #(
    .NUM_SETS      (NUM_SETS),
    .MAX_INTERVALS (MAX_INTERVALS),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (in_i.opcode),
    .set_index_i      (in_i.set_index),
    .entry_index_i    (in_i.entry_index),
    .range_low_i      (in_i.range_low),
    .range_high_i     (in_i.range_high),
    .status_o         (out_o.status),
    .interval_count_o (out_o.interval_count),
    .entry_low_o      (out_o.entry_low),
    .entry_high_o     (out_o.entry_high)
  );

endmodule

// ----- verif/interval_set_merge_insert_test.sv -----
module interval_set_merge_insert_test
  import isms_pkg::*;
();

  localparam int NSETS = DEF_NUM_SETS;
  localparam int CAP   = DEF_MAX_INTERVALS;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [FIELD_W-1:0]  lo;
    logic [FIELD_W-1:0]  hi;
  } reply_t;

  // scoreboard: golden interval sets plus queue of pending replies
  class interval_scoreboard;
    longint lows[NSETS][CAP];
    longint highs[NSETS][CAP];
    int     counts[NSETS];
    reply_t pending[$];
    int     errors;

    function new();
      errors = 0;
      for (int s = 0; s < NSETS; s++) counts[s] = 0;
    endfunction

    // merge [a,b] into a set, returns status
    function status_e merge_insert(int s, longint a, longint b);
      longint nl[CAP+1];
      longint nh[CAP+1];
      int n;
      bit placed;
      n = 0;
      placed = 0;
      for (int k = 0; k < counts[s]; k++) begin
        if (highs[s][k] + 1 < a) begin
          if (n > CAP) return ST_OVERFLOW;
          nl[n] = lows[s][k]; nh[n] = highs[s][k]; n++;
        end else if (lows[s][k] > b + 1) begin
          if (!placed) begin
            if (n > CAP) return ST_OVERFLOW;
            nl[n] = a; nh[n] = b; n++;
            placed = 1;
          end
          if (n > CAP) return ST_OVERFLOW;
          nl[n] = lows[s][k]; nh[n] = highs[s][k]; n++;
        end else begin
          if (lows[s][k] < a) a = lows[s][k];
          if (highs[s][k] > b) b = highs[s][k];
        end
      end
      if (!placed) begin
        if (n > CAP) return ST_OVERFLOW;
        nl[n] = a; nh[n] = b; n++;
      end
      if (n > CAP) return ST_OVERFLOW;
      for (int k = 0; k < n; k++) begin
        lows[s][k] = nl[k];
        highs[s][k] = nh[k];
      end
      counts[s] = n;
      return ST_OK;
    endfunction

    // note an accepted input item
    function void note_item(logic [1:0] op, logic [1:0] set, logic [3:0] idx,
                            logic signed [31:0] a, logic signed [31:0] b);
      reply_t r;
      int s;
      r = '0;
      s = int'(set);
      if (s >= NSETS) begin
        r.status = ST_BAD;
      end else begin
        case (op)
          OP_INSERT: begin
            if (a > b) r.status = ST_BAD;
            else r.status = merge_insert(s, longint'(a), longint'(b));
          end
          OP_CLEAR: counts[s] = 0;
          OP_READ: begin
            if (idx < counts[s]) begin
              r.lo = lows[s][idx][31:0];
              r.hi = highs[s][idx][31:0];
            end else begin
              r.status = ST_BAD;
            end
          end
          default: r.status = ST_BAD;
        endcase
        r.count = COUNT_W'(counts[s]);
      end
      pending = {pending, r};
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    // check one accepted result item
    task check_reply(reply_t got);
      reply_t want;
      if (pending.size() == 0) begin
        report("unexpected item", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        report("status", int'(got.status), int'(want.status));
      if (got.count !== want.count)
        report("interval_count", int'(got.count), int'(want.count));
      if (got.lo !== want.lo) report("entry_low", int'(got.lo), int'(want.lo));
      if (got.hi !== want.hi) report("entry_high", int'(got.hi), int'(want.hi));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  isms_in_if  in_ch();
  isms_out_if out_ch();

  interval_set_merge_insert dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  interval_scoreboard sets_model;
  bit quiet_phase;
  int idle_cycles;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // input defaults and reset
  initial begin
    sets_model = new();
    quiet_phase = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.set_index = '0;
    in_ch.entry_index = '0;
    in_ch.range_low = '0;
    in_ch.range_high = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // random sink stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ch.ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 10);
    end
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sets_model.check_reply({out_ch.status, out_ch.interval_count,
                              out_ch.entry_low, out_ch.entry_high});
    end
  end

  // watchdog on cycles without any item moving
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // send one item, waits for the handshake
  task send_item(logic [1:0] op, logic [1:0] set, logic [3:0] idx,
                 logic signed [31:0] a, logic signed [31:0] b);
    while (!quiet_phase && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.set_index <= set;
    in_ch.entry_index <= idx;
    in_ch.range_low <= a;
    in_ch.range_high <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sets_model.note_item(op, set, idx, a, b);
  endtask

  task drain_replies();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sets_model.pending.size() != 0) @(posedge clk_i);
  endtask

  // random coordinate: mostly a narrow window so merges happen
  function logic [31:0] rand_coord(int win);
    int r;
    r = $urandom_range(99);
    if (r < 5) return 32'h8000_0000;
    if (r < 10) return 32'h7fff_ffff;
    if (r < 18) return $urandom();
    return 32'($urandom_range(win)) - 32'(win / 2);
  endfunction

  initial begin
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] t;
    int op_pick;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);

    // directed: extremes, merges, adjacency, errors
    send_item(OP_READ, 0, 0, 0, 0);
    send_item(OP_INSERT, 0, 0, 32'sh7fff_fff0, 32'sh7fff_ffff);
    send_item(OP_INSERT, 0, 0, 32'sh8000_0000, 32'sh8000_0005);
    send_item(OP_INSERT, 0, 0, 10, 20);
    send_item(OP_INSERT, 0, 0, 21, 25);
    send_item(OP_INSERT, 0, 0, 0, 8);
    send_item(OP_INSERT, 0, 0, 9, 9);
    send_item(OP_INSERT, 0, 0, 5, 4);
    send_item(OP_READ, 0, 1, 0, 0);
    send_item(OP_READ, 0, 2, 0, 0);
    send_item(OP_READ, 0, 15, 0, 0);
    send_item(2'd3, 1, 0, 0, 0);
    send_item(OP_INSERT, 3, 0, -100, 100);
    send_item(OP_CLEAR, 0, 0, 0, 0);
    send_item(OP_READ, 0, 0, 0, 0);
    // fill set 1 to capacity, then overflow
    for (int k = 0; k < CAP; k++) send_item(OP_INSERT, 1, 0, k * 4, k * 4 + 1);
    send_item(OP_INSERT, 1, 0, 1000, 1001);
    send_item(OP_INSERT, 1, 0, 2, 2);
    send_item(OP_INSERT, 1, 0, -5, 200);
    send_item(OP_READ, 1, 0, 0, 0);

    // wait for every pending reply before going on
    drain_replies();

    // random part, with a middle stretch without stalls
    for (int i = 0; i < 550; i++) begin
      quiet_phase = (i >= 100 && i < 200);
      op_pick = $urandom_range(99);
      a = rand_coord((i % 200 < 100) ? 400 : 60);
      b = rand_coord((i % 200 < 100) ? 400 : 60);
      if ($urandom_range(9) != 0 && $signed(a) > $signed(b)) begin
        t = a; a = b; b = t;
      end
      if ($signed(b) - $signed(a) > 30 && $urandom_range(3) != 0 && a < 32'h7fff_ff00)
        b = a + $urandom_range(30);
      if (op_pick < 60)
        send_item(OP_INSERT, 2'($urandom_range(3)), 4'($urandom()), a, b);
      else if (op_pick < 63)
        send_item(OP_CLEAR, 2'($urandom_range(3)), 4'($urandom()), $urandom(), $urandom());
      else if (op_pick < 97)
        send_item(OP_READ, 2'($urandom_range(3)), 4'($urandom()), $urandom(), $urandom());
      else
        send_item(2'd3, 2'($urandom_range(3)), 4'($urandom()), $urandom(), $urandom());
    end
    quiet_phase = 0;
    drain_replies();
    repeat (100) @(posedge clk_i);
    if (sets_model.errors == 0 && sets_model.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- interval_set_merge_insert.f -----
+incdir+hw/rtl
hw/rtl/isms_pkg.sv
hw/rtl/isms_in_if.sv
hw/rtl/isms_out_if.sv
hw/rtl/isms_ram.sv
hw/rtl/isms_ctrl.sv
hw/rtl/isms_dp.sv
hw/rtl/interval_set_merge_insert.sv
verif/interval_set_merge_insert_test.sv
